/* design/dmx_pkg.sv */
// shared constants, register indexes and types for the downmix history block
package dmx_pkg;

	// field widths
	localparam int SAMPLE_W   = 16;
	localparam int NUM_CHAN   = 8;
	localparam int CH_CNT_W   = 4;
	localparam int KEEP_W     = 10;
	localparam int AGE_W      = 10;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 1;

	// parameter defaults
	localparam int DEF_HISTORY_DEPTH = 1024;
	localparam int DEF_MAX_CHANNELS  = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT    = 1'b1;

	// register reset values
	localparam logic [CH_CNT_W-1:0] CHANNEL_COUNT_RST = 4'd2;
	localparam logic [KEEP_W-1:0]   KEEP_COUNT_RST    = 10'd0;

	// command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// request from the sequencer to the history store
	typedef struct packed {
		logic                push;
		logic [SAMPLE_W-1:0] push_data;
		logic                rd;
		logic [AGE_W-1:0]    rd_age;
	} hist_req_t;

	// answer of the history store to a read
	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                has_data;
		logic                filled;
	} hist_rsp_t;

endpackage

/* design/audio_downmix_history_capture.sv */
// top level: command sequencer, channel accumulator, output register
//
//  channel | beat                                      | handshake
//  --------+-------------------------------------------+------------------------------
//  in      | command, chan_0..chan_7, read_age         | in_valid / in_ready
//  out     | mono_value, has_data, entry_filled        | out_valid / out_ready
//  cfg     | cfg_index, cfg_data                       | cfg_we, no wait
//
// a push adds the n channels one per cycle through one adder, then the divider yields one
// quotient bit per cycle. a read goes through the registered memory read port.
// in_ready is high only while the sequencer is idle; a read waits in its last step
// while the output register still holds an untaken beat.
// reset clears the pointer, fill level, config registers, sequencer state and out_valid; history memory is not cleared.
module audio_downmix_history_capture #(
	parameter int HISTORY_DEPTH = dmx_pkg::DEF_HISTORY_DEPTH,
	parameter int MAX_CHANNELS  = dmx_pkg::DEF_MAX_CHANNELS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dmx_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dmx_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0] chan_0,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0] chan_1,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0] chan_2,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0] chan_3,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0] chan_4,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0] chan_5,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0] chan_6,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0] chan_7,
	input  logic [dmx_pkg::AGE_W-1:0]          read_age,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [dmx_pkg::SAMPLE_W-1:0] mono_value,
	output logic                               has_data,
	output logic                               entry_filled
);

	localparam int SW    = dmx_pkg::SAMPLE_W;
	localparam int CNW   = dmx_pkg::CH_CNT_W;
	localparam int SUM_W = SW + $clog2(MAX_CHANNELS);
	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;
	localparam logic [2:0] ST_SGN  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;
	localparam logic [2:0] ST_RD   = 3'd5;
	localparam logic [2:0] ST_RSP  = 3'd6;

	logic [2:0]              state_q;
	logic [CNW-1:0]          chan_cnt_q;
	logic [dmx_pkg::KEEP_W-1:0] keep_q;
	logic [CNW-1:0]          n_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    neg_q;
	logic [dmx_pkg::AGE_W-1:0] age_q;
	logic signed [SW-1:0]    smp_q [MAX_CHANNELS];

	logic                    out_valid_q;
	logic [SW-1:0]           mono_q;
	logic                    has_q;
	logic                    filled_q;

	logic signed [SW-1:0]    chan_in [dmx_pkg::NUM_CHAN];
	logic [CNW-1:0]          n_eff;
	logic                    acc_last;
	logic [SUM_W-1:0]        mag;
	logic                    div_start;
	logic                    div_done;
	logic [SUM_W-1:0]        div_quo;
	logic [SW-1:0]           quo_trunc;
	logic                    in_acc;
	logic                    out_free;

	dmx_pkg::hist_req_t      hreq;
	dmx_pkg::hist_rsp_t      hrsp;

	// channel ports as an array
	always_comb begin
		chan_in[0] = chan_0;
		chan_in[1] = chan_1;
		chan_in[2] = chan_2;
		chan_in[3] = chan_3;
		chan_in[4] = chan_4;
		chan_in[5] = chan_5;
		chan_in[6] = chan_6;
		chan_in[7] = chan_7;
	end

	// effective channel count, saturated to the number of lanes
	always_comb begin
		if (chan_cnt_q > CNW'(MAX_CHANNELS)) begin
			n_eff = CNW'(MAX_CHANNELS);
		end else begin
			n_eff = chan_cnt_q;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign acc_last  = CNW'(idx_q) == (n_q - 1'b1);
	assign mag       = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign div_start = state_q == ST_SGN;
	assign quo_trunc = neg_q ? SW'(-div_quo) : SW'(div_quo);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= dmx_pkg::CHANNEL_COUNT_RST;
			keep_q     <= dmx_pkg::KEEP_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dmx_pkg::REG_CHANNEL_COUNT: chan_cnt_q <= cfg_data[CNW-1:0];
				dmx_pkg::REG_KEEP_COUNT:    keep_q     <= cfg_data[dmx_pkg::KEEP_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idx_q <= '0;
						if (command == dmx_pkg::CMD_READ) begin
							state_q <= ST_RD;
						end else if (n_eff != '0) begin
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					idx_q <= idx_q + 1'b1;
					if (acc_last) begin
						state_q <= ST_SGN;
					end
				end
				ST_SGN: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: state_q <= ST_IDLE;
				ST_RD: state_q <= ST_RSP;
				ST_RSP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// beat capture and channel accumulation through the shared adder
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int k = 0; k < MAX_CHANNELS; k++) begin
				smp_q[k] <= chan_in[k];
			end
			n_q   <= n_eff;
			age_q <= read_age;
			sum_q <= '0;
		end else if (state_q == ST_ACC) begin
			sum_q <= sum_q + SUM_W'(smp_q[idx_q]);
		end
		if (state_q == ST_SGN) begin
			neg_q <= sum_q[SUM_W-1];
		end
	end

	// sign is taken in the same cycle that loads the divider
	dmx_div #(
		.DIVIDEND_W(SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// requests to the history store
	always_comb begin
		hreq.push      = state_q == ST_WR;
		hreq.push_data = quo_trunc;
		hreq.rd        = state_q == ST_RD;
		hreq.rd_age    = age_q;
	end

	dmx_hist #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk        (clk),
		.arst_n     (arst_n),
		.keep_count (keep_q),
		.req        (hreq),
		.rsp        (hrsp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RSP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RSP && out_free) begin
			mono_q   <= hrsp.value;
			has_q    <= hrsp.has_data;
			filled_q <= hrsp.filled;
		end
	end

	assign out_valid    = out_valid_q;
	assign mono_value   = mono_q;
	assign has_data     = has_q;
	assign entry_filled = filled_q;

endmodule

/* design/dmx_div.sv */
// iterative restoring divider, one quotient bit per cycle, small unsigned divisor
module dmx_div #(
	parameter int DIVIDEND_W = 19
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [DIVIDEND_W-1:0]          dividend,
	input  logic [dmx_pkg::CH_CNT_W-1:0]   divisor,
	output logic                           done,
	output logic [DIVIDEND_W-1:0]          quotient
);

	localparam int DW    = dmx_pkg::CH_CNT_W;
	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DW:0]       rem_q;
	logic [DW-1:0]     div_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [DW:0] trial;
	logic        fits;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q[DW-1:0], quo_q[DIVIDEND_W-1]};
		fits  = trial >= {1'b0, div_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath: quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, div_q}) : trial;
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/dmx_hist.sv */
// circular history memory with newest pointer, fill level and age lookup
module dmx_hist #(
	parameter int HISTORY_DEPTH = dmx_pkg::DEF_HISTORY_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [dmx_pkg::KEEP_W-1:0]   keep_count,
	input  dmx_pkg::hist_req_t           req,
	output dmx_pkg::hist_rsp_t           rsp
);

	localparam int PTR_W  = $clog2(HISTORY_DEPTH);
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int CW     = (FILL_W > dmx_pkg::AGE_W) ? FILL_W + 1 : dmx_pkg::AGE_W + 1;

	logic [dmx_pkg::SAMPLE_W-1:0] mem [HISTORY_DEPTH];

	logic [PTR_W-1:0]  newest_q;
	logic [FILL_W-1:0] fill_q;
	logic [dmx_pkg::SAMPLE_W-1:0] rdata_q;
	logic              filled_q;
	logic              has_q;

	logic [PTR_W-1:0]  next_ptr;
	logic [CW-1:0]     keep_w;
	logic [CW-1:0]     keep_sat;
	logic [FILL_W-1:0] fill_next;
	logic              rd_filled;
	logic [CW-1:0]     diff;
	logic [CW-1:0]     slot_w;
	logic [PTR_W-1:0]  slot;

	// pointer advance and fill level update on a push
	always_comb begin
		if (newest_q == PTR_W'(HISTORY_DEPTH - 1)) begin
			next_ptr = '0;
		end else begin
			next_ptr = newest_q + 1'b1;
		end
		keep_w = CW'(keep_count);
		if (keep_w > CW'(HISTORY_DEPTH - 1)) begin
			keep_sat = CW'(HISTORY_DEPTH - 1);
		end else begin
			keep_sat = keep_w;
		end
		if (CW'(fill_q) >= CW'(HISTORY_DEPTH)) begin
			fill_next = FILL_W'(keep_sat + 1'b1);
		end else begin
			fill_next = fill_q + 1'b1;
		end
	end

	// slot of the entry at the requested age
	always_comb begin
		rd_filled = CW'(req.rd_age) < CW'(fill_q);
		diff      = CW'(newest_q) - CW'(req.rd_age);
		if (diff[CW-1]) begin
			slot_w = diff + CW'(HISTORY_DEPTH);
		end else begin
			slot_w = diff;
		end
		slot = slot_w[PTR_W-1:0];
	end

	// pointer and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			fill_q   <= '0;
		end else if (req.push) begin
			newest_q <= next_ptr;
			fill_q   <= fill_next;
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (req.push) begin
			mem[next_ptr] <= req.push_data;
		end
		if (req.rd) begin
			rdata_q  <= mem[slot];
			filled_q <= rd_filled;
			has_q    <= fill_q != '0;
		end
	end

	assign rsp.value    = filled_q ? rdata_q : '0;
	assign rsp.has_data = has_q;
	assign rsp.filled   = filled_q;

endmodule
